>>> rtl/source_tokenizer_core_defines.svh
// assertion macros for the source tokenizer
// no dependencies
`ifndef SOURCE_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_TOKENIZER_CORE_DEFINES_SVH
`ifndef SYNTH
`define STK_ASSERT(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define STK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define STK_ASSERT(label, clk, rst_n, cond)
`define STK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/stk_pkg.sv
// types, token codes and helper functions for the source tokenizer
// no dependencies
`timescale 1ns / 1ps
package stk_pkg;
  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned LINE_BITS = 16;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_IDX_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned WIDE_W = 33;

  localparam logic [5:0] K_EOF = 6'd0, K_ERROR = 6'd1, K_INT = 6'd2, K_FLOAT = 6'd3,
    K_STRING = 6'd4, K_IDENT = 6'd5, K_IF = 6'd6, K_ELSE = 6'd7, K_WHILE = 6'd8,
    K_LET = 6'd9, K_INT_KW = 6'd10, K_FLOAT_KW = 6'd11, K_STR = 6'd12, K_BOOL = 6'd13,
    K_BOOL_LIT = 6'd14, K_FN = 6'd15, K_NULL = 6'd16, K_PLUS = 6'd17, K_MINUS = 6'd18,
    K_STAR = 6'd19, K_SLASH = 6'd20, K_ASSIGN = 6'd21, K_BANG = 6'd23, K_LT = 6'd25,
    K_GT = 6'd27, K_LPAREN = 6'd29, K_RPAREN = 6'd30, K_LBRACE = 6'd31,
    K_RBRACE = 6'd32, K_COMMA = 6'd33, K_SEMI = 6'd34;

  localparam logic [1:0] E_NONE = 2'd0, E_UNTERM = 2'd1, E_UNEXPECTED = 2'd2;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_NUMBER, M_NUMDOT, M_FRAC, M_IDENT, M_STRING, M_OPEQ
  } mode_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [15:0] line;
    logic [1:0]  err;
    logic        last;
  } token_t;

  function automatic logic [15:0] clip16(input logic [WIDE_W-1:0] v);
    clip16 = (v > WIDE_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  // buffer holds first char in the low byte, so literals are reversed
  function automatic logic [5:0] ident_kind(input logic [15:0] len, input logic [39:0] kw);
    ident_kind = K_IDENT;
    case (len)
      16'd2: begin
        if (kw[15:0] == "fi") ident_kind = K_IF;
        else if (kw[15:0] == "nf") ident_kind = K_FN;
      end
      16'd3: begin
        if (kw[23:0] == "tel") ident_kind = K_LET;
        else if (kw[23:0] == "tni") ident_kind = K_INT_KW;
        else if (kw[23:0] == "rts") ident_kind = K_STR;
      end
      16'd4: begin
        if (kw[31:0] == "esle") ident_kind = K_ELSE;
        else if (kw[31:0] == "loob") ident_kind = K_BOOL;
        else if (kw[31:0] == "eurt") ident_kind = K_BOOL_LIT;
        else if (kw[31:0] == "llun") ident_kind = K_NULL;
      end
      16'd5: begin
        if (kw == "elihw") ident_kind = K_WHILE;
        else if (kw == "taolf") ident_kind = K_FLOAT_KW;
        else if (kw == "eslaf") ident_kind = K_BOOL_LIT;
      end
      default: ident_kind = K_IDENT;
    endcase
  endfunction
endpackage

>>> rtl/stk_byte_if.sv
// valid/ready channel for source bytes
// no dependencies
`timescale 1ns / 1ps
interface stk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

>>> rtl/stk_token_if.sv
// valid/ready channel for tokens
// no dependencies
`timescale 1ns / 1ps
interface stk_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [15:0] token_offset;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic [1:0]  error_kind;
  logic        last_of_run;
  modport source (output valid, output token_kind, output token_offset,
    output token_length, output token_line, output error_kind, output last_of_run,
    input ready);
  modport sink (input valid, input token_kind, input token_offset, input token_length,
    input token_line, input error_kind, input last_of_run, output ready);
endinterface

>>> rtl/source_tokenizer_core.sv
// source tokenizer top level: lexer state and token queue
// depends on stk_pkg, stk_byte_if, stk_token_if, source_tokenizer_core_defines.svh
//
// channel   dir  transaction
// in_if     in   one source byte (0 ends the source)
// out_if    out  one token
//
// one byte is taken per cycle while the eight-entry token queue has room for three
// a byte yields zero to three tokens, written to the queue in the same cycle
// tokens leave the queue one per cycle while out_if.ready is high, so the queue drain rate sets the byte rate
// rst_ni clears the lexer state and empties the queue
`timescale 1ns / 1ps
`include "source_tokenizer_core_defines.svh"
module source_tokenizer_core (
  input logic clk_i,
  input logic rst_ni,
  stk_byte_if.sink in_if,
  stk_token_if.source out_if
);
  import stk_pkg::*;

  mode_e mode_q, mode_d;
  logic [OFFSET_BITS-1:0] off_q, off_d, start_q, start_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [39:0] kw_q, kw_d;
  logic [7:0] pend_q, pend_d;
  logic [15:0] len_q, len_d;

  token_t fifo_q [FIFO_DEPTH];
  logic [FIFO_IDX_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  token_t tok [3];
  logic [1:0] ntok;
  logic in_fire, out_fire, eof_fire;

  assign in_if.ready = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 3);
  assign in_fire = in_if.valid && in_if.ready;
  assign eof_fire = in_fire && (in_if.source_byte == 8'h00);
  assign out_if.valid = cnt_q != '0;
  assign out_fire = out_if.valid && out_if.ready;
  assign out_if.token_kind = fifo_q[rd_q].kind;
  assign out_if.token_offset = fifo_q[rd_q].offset;
  assign out_if.token_length = fifo_q[rd_q].length;
  assign out_if.token_line = fifo_q[rd_q].line;
  assign out_if.error_kind = fifo_q[rd_q].err;
  assign out_if.last_of_run = fifo_q[rd_q].last;

  always_comb begin
    logic [7:0] c;
    logic used, dig, alph;
    logic [15:0] ln;
    logic [5:0] base;
    c = in_if.source_byte;
    used = 1'b0;
    dig = (c >= "0") && (c <= "9");
    alph = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    ln = clip16(WIDE_W'(line_q));
    base = (pend_q == "=") ? K_ASSIGN : (pend_q == "!") ? K_BANG :
           (pend_q == "<") ? K_LT : K_GT;
    mode_d = mode_q;
    off_d = off_q;
    start_d = start_q;
    line_d = line_q;
    kw_d = kw_q;
    pend_d = pend_q;
    len_d = len_q;
    ntok = 2'd0;
    for (int i = 0; i < 3; i++) tok[i] = '0;

    case (mode_q)
      M_SLASH: begin
        if (c == "/") begin
          mode_d = M_COMMENT;
          used = 1'b1;
        end else begin
          tok[ntok] = '{K_SLASH, clip16(WIDE_W'(start_q)), 16'd1, ln, E_NONE, 1'b0};
          ntok = ntok + 2'd1;
        end
      end
      M_COMMENT: used = (c != 8'h0A) && (c != 8'h00);
      M_NUMBER: begin
        if (dig) begin
          len_d = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
          used = 1'b1;
        end else if (c == ".") begin
          mode_d = M_NUMDOT;
          used = 1'b1;
        end else begin
          tok[ntok] = '{K_INT, clip16(WIDE_W'(start_q)), len_q, ln, E_NONE, 1'b0};
          ntok = ntok + 2'd1;
        end
      end
      M_NUMDOT: begin
        if (dig) begin
          len_d = (len_q >= 16'hFFFE) ? 16'hFFFF : len_q + 16'd2;
          mode_d = M_FRAC;
          used = 1'b1;
        end else begin
          tok[ntok] = '{K_INT, clip16(WIDE_W'(start_q)), len_q, ln, E_NONE, 1'b0};
          ntok = ntok + 2'd1;
          tok[ntok] = '{K_ERROR, clip16(WIDE_W'(start_q) + WIDE_W'(len_q)), 16'd1, ln,
                        E_UNEXPECTED, 1'b0};
          ntok = ntok + 2'd1;
        end
      end
      M_FRAC: begin
        if (dig) begin
          len_d = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
          used = 1'b1;
        end else begin
          tok[ntok] = '{K_FLOAT, clip16(WIDE_W'(start_q)), len_q, ln, E_NONE, 1'b0};
          ntok = ntok + 2'd1;
        end
      end
      M_IDENT: begin
        if (alph || dig) begin
          if (len_q < 16'd5) kw_d[{len_q[2:0], 3'b000} +: 8] = c;
          len_d = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
          used = 1'b1;
        end else begin
          tok[ntok] = '{ident_kind(len_q, kw_q), clip16(WIDE_W'(start_q)), len_q, ln,
                        E_NONE, 1'b0};
          ntok = ntok + 2'd1;
        end
      end
      M_STRING: begin
        if (c == "\"") begin
          len_d = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
          tok[ntok] = '{K_STRING, clip16(WIDE_W'(start_q)), len_d, ln, E_NONE, 1'b0};
          ntok = ntok + 2'd1;
          mode_d = M_IDLE;
          used = 1'b1;
        end else if (c == 8'h00) begin
          tok[ntok] = '{K_ERROR, clip16(WIDE_W'(start_q)), len_q, ln, E_UNTERM, 1'b0};
          ntok = ntok + 2'd1;
        end else begin
          if (c == 8'h0A && line_q != '1) line_d = line_q + LINE_BITS'(1);
          len_d = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
          used = 1'b1;
        end
      end
      M_OPEQ: begin
        if (c == "=") begin
          tok[ntok] = '{base + 6'd1, clip16(WIDE_W'(start_q)), 16'd2, ln, E_NONE, 1'b0};
          ntok = ntok + 2'd1;
          mode_d = M_IDLE;
          used = 1'b1;
        end else begin
          tok[ntok] = '{base, clip16(WIDE_W'(start_q)), 16'd1, ln, E_NONE, 1'b0};
          ntok = ntok + 2'd1;
        end
      end
      default: used = 1'b0;
    endcase

    if (!used) begin
      mode_d = M_IDLE;
      if (c == 8'h00) begin
        tok[ntok] = '{K_EOF, clip16(WIDE_W'(off_q)), 16'd0, ln, E_NONE, 1'b0};
        ntok = ntok + 2'd1;
      end else begin
        case (c) inside
          " ", 8'h0D, 8'h09: used = 1'b0;
          8'h0A: if (line_q != '1) line_d = line_q + LINE_BITS'(1);
          "/", "\"", "=", "!", "<", ">": begin
            mode_d = (c == "/") ? M_SLASH : (c == "\"") ? M_STRING : M_OPEQ;
            start_d = off_q;
            len_d = 16'd1;
            if (mode_d == M_OPEQ) pend_d = c;
          end
          "+", "-", "*", "(", ")", "{", "}", ",", ";": begin
            tok[ntok] = '{(c == "+") ? K_PLUS : (c == "-") ? K_MINUS :
                          (c == "*") ? K_STAR : (c == "(") ? K_LPAREN :
                          (c == ")") ? K_RPAREN : (c == "{") ? K_LBRACE :
                          (c == "}") ? K_RBRACE : (c == ",") ? K_COMMA : K_SEMI,
                          clip16(WIDE_W'(off_q)), 16'd1, ln, E_NONE, 1'b0};
            ntok = ntok + 2'd1;
          end
          default: begin
            if (dig || alph) begin
              mode_d = dig ? M_NUMBER : M_IDENT;
              start_d = off_q;
              len_d = 16'd1;
              if (alph) kw_d = {32'd0, c};
            end else begin
              tok[ntok] = '{K_ERROR, clip16(WIDE_W'(off_q)), 16'd1, ln, E_UNEXPECTED,
                            1'b0};
              ntok = ntok + 2'd1;
            end
          end
        endcase
      end
    end
    off_d = (off_q == '1) ? off_q : off_q + OFFSET_BITS'(1);
    if (!used && c == 8'h00) begin
      mode_d = M_IDLE;
      off_d = '0;
      start_d = '0;
      line_d = LINE_BITS'(1);
      kw_d = '0;
      pend_d = '0;
      len_d = '0;
    end
    if (ntok != 2'd0) tok[ntok - 2'd1].last = 1'b1;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) cnt_d = cnt_d + FIFO_CNT_W'(ntok);
    if (out_fire) cnt_d = cnt_d - FIFO_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      off_q <= '0;
      start_q <= '0;
      line_q <= LINE_BITS'(1);
      kw_q <= '0;
      pend_q <= '0;
      len_q <= '0;
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (in_fire) begin
        mode_q <= mode_d;
        off_q <= off_d;
        start_q <= start_d;
        line_q <= line_d;
        kw_q <= kw_d;
        pend_q <= pend_d;
        len_q <= len_d;
        wr_q <= wr_q + FIFO_IDX_W'(ntok);
      end
      if (out_fire) rd_q <= rd_q + FIFO_IDX_W'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < ntok) fifo_q[wr_q + FIFO_IDX_W'(k)] <= tok[k];
      end
    end
  end

  `STK_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
  `STK_ASSERT(a_ptr_gap, clk_i, rst_ni, FIFO_IDX_W'(wr_q - rd_q) == cnt_q[FIFO_IDX_W-1:0])
  `STK_ASSERT_IMP(a_eof_reset, clk_i, rst_ni, eof_fire, off_q == '0 && line_q == LINE_BITS'(1))
endmodule
